// ===== hdl/fcce_pkg.sv =====
// Shared types and constants for the cluster chain engine.
// No dependencies; imported by every module of the block.
package fcce_pkg;

	localparam logic [2:0] KIND_READ  = 3'd0;
	localparam logic [2:0] KIND_WRITE = 3'd1;
	localparam logic [2:0] KIND_NTH   = 3'd2;
	localparam logic [2:0] KIND_FIND  = 3'd3;
	localparam logic [2:0] KIND_FREE  = 3'd4;

	localparam logic [2:0] STAT_OK     = 3'd0;
	localparam logic [2:0] STAT_ENDED  = 3'd1;
	localparam logic [2:0] STAT_BADFS  = 3'd2;
	localparam logic [2:0] STAT_FULL   = 3'd3;
	localparam logic [2:0] STAT_BADDEV = 3'd4;

	localparam logic [31:0] ENT_EOC   = 32'h0FFF_FFF8;
	localparam logic [27:0] LINK_BAD  = 28'hFFF_FFF7;
	localparam logic [27:0] LINK_FREE = 28'h000_0000;
	localparam logic [31:0] ENT_EMPTY = 32'h0000_0000;
	localparam logic [27:0] HINT_INIT = 28'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [27:0] cluster;
		logic [15:0] step_count;
		logic [31:0] write_value;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] entry_value;
		logic [27:0] found_cluster;
	} result_t;

	// single port table access: either a read or a write in one cycle
	typedef struct packed {
		logic        rd_en;
		logic        wr_en;
		logic [27:0] addr;
		logic [31:0] wdata;
	} tbl_req_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL
	} fsm_t;

endpackage

// ===== hdl/fat_cluster_chain_engine_unit.sv =====
// Top level of the cluster chain engine: cluster_count register, sequencer
// and table RAM. Depends on fcce_pkg, fcce_ctrl and fcce_table.
//
//  channel   | ports                      | transaction
//  ----------+----------------------------+---------------------------------
//  command   | start, busy, cmd           | edge with start high, busy low
//  result    | done, result               | one cycle strobe, no back-pressure
//  config    | cfg_we, cfg_wdata          | edge with cfg_we high
//
// Read issues the table read in S_READ and returns it from S_EVAL; write
// completes in S_READ. Nth-in-chain and free chain take one S_READ and one
// S_EVAL per link; find free takes one per candidate scanned; the single-port
// table (one read, then the evaluation and any write-back) sets this. Reset
// clears the table one entry a cycle: busy stays high until the last entry is cleared. Results cannot stall.
module fat_cluster_chain_engine_unit import fcce_pkg::*; #(
	parameter int TABLE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        done,
	output result_t     result,
	input  logic        cfg_we,
	input  logic [11:0] cfg_wdata
);

	localparam int ADDR_W = $clog2(TABLE_DEPTH);

	logic [11:0] cluster_count_q;
	tbl_req_t    tbl_req;
	logic [31:0] tbl_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= 12'd4094;
		end else if (cfg_we) begin
			cluster_count_q <= cfg_wdata;
		end
	end

	fcce_ctrl #(
		.DEPTH  (TABLE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.cmd           (cmd),
		.cluster_count (cluster_count_q),
		.busy          (busy),
		.tbl_req       (tbl_req),
		.tbl_rdata     (tbl_rdata),
		.result        (result),
		.done          (done)
	);

	fcce_table #(
		.DEPTH  (TABLE_DEPTH),
		.ADDR_W (ADDR_W)
	) u_table (
		.clk   (clk),
		.req   (tbl_req),
		.rdata (tbl_rdata)
	);

endmodule

// ===== hdl/fcce_table.sv =====
// Allocation table storage: single port synchronous RAM, registered read.
// Depends on fcce_pkg for the request struct.
module fcce_table import fcce_pkg::*; #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  logic        clk,
	input  tbl_req_t    req,
	output logic [31:0] rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr[ADDR_W-1:0]] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata <= mem[req.addr[ADDR_W-1:0]];
		end
	end

endmodule

// ===== hdl/fcce_ctrl.sv =====
// Operation sequencer: clearing pass, read/modify/write of table entries,
// chain walks, free scan and free hint. Depends on fcce_pkg.
module fcce_ctrl import fcce_pkg::*; #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  cmd_t        cmd,
	input  logic [11:0] cluster_count,
	output logic        busy,
	output tbl_req_t    tbl_req,
	input  logic [31:0] tbl_rdata,
	output result_t     result,
	output logic        done
);

	localparam logic [27:0] DEPTH_C = 28'(DEPTH);
	localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

	fsm_t              state_q, state_nxt;
	logic [ADDR_W-1:0] clr_q;
	logic [2:0]        kind_q;
	logic [27:0]       cur_q;
	logic [15:0]       cnt_q;
	logic [31:0]       wv_q;
	logic [31:0]       ent_q;
	logic [27:0]       hint_q;

	logic        fin;
	result_t     fin_res;
	logic        adv;        // advance to the next link or candidate
	logic [27:0] adv_cur;
	logic        hint_we;
	logic [12:0] total;
	logic [27:0] link;
	logic        e_end, e_bad, e_free, in_range;

	assign total    = {1'b0, cluster_count} + 13'd2;
	assign link     = tbl_rdata[27:0];
	assign e_end    = tbl_rdata >= ENT_EOC;
	assign e_bad    = link == LINK_BAD;
	assign e_free   = link == LINK_FREE;
	assign in_range = cur_q < DEPTH_C;
	assign busy     = state_q != S_IDLE;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == CLR_LAST) state_nxt = S_IDLE;
			S_IDLE:  if (start) state_nxt = S_READ;
			S_READ:  state_nxt = fin ? S_IDLE : S_EVAL;
			S_EVAL:  state_nxt = fin ? S_IDLE : S_READ;
			default: state_nxt = S_IDLE;
		endcase
	end

	// per-state decisions and table access
	always_comb begin
		fin     = 1'b0;
		fin_res = '{status: STAT_OK, entry_value: ENT_EMPTY, found_cluster: cur_q};
		adv     = 1'b0;
		adv_cur = cur_q;
		hint_we = 1'b0;
		tbl_req = '{rd_en: 1'b0, wr_en: 1'b0, addr: cur_q, wdata: ENT_EMPTY};
		unique case (state_q)
			S_CLEAR: begin
				tbl_req.wr_en = 1'b1;
				tbl_req.addr  = 28'(clr_q);
			end
			S_IDLE: ;
			S_READ: begin
				if (kind_q > KIND_FREE) begin
					fin     = 1'b1;
					fin_res = '{status: STAT_BADDEV, entry_value: ENT_EMPTY,
						found_cluster: LINK_FREE};
				end else if (kind_q == KIND_NTH && cnt_q == 16'd0) begin
					fin                 = 1'b1;
					fin_res.entry_value = ent_q;
				end else if (kind_q == KIND_FIND && cur_q >= 28'(total)) begin
					fin     = 1'b1;
					fin_res = '{status: STAT_FULL, entry_value: ENT_EMPTY,
						found_cluster: LINK_FREE};
				end else if (!in_range) begin
					fin            = 1'b1;
					fin_res.status = STAT_BADDEV;
				end else if (kind_q == KIND_WRITE) begin
					fin                 = 1'b1;
					fin_res.entry_value = wv_q;
					tbl_req.wr_en       = 1'b1;
					tbl_req.wdata       = wv_q;
				end else begin
					tbl_req.rd_en = 1'b1;
				end
			end
			S_EVAL: begin
				fin_res.entry_value = tbl_rdata;
				case (kind_q)
					KIND_NTH: begin
						if (e_end) begin
							fin            = 1'b1;
							fin_res.status = STAT_ENDED;
						end else if (e_bad || e_free) begin
							fin                   = 1'b1;
							fin_res.status        = STAT_BADFS;
							fin_res.found_cluster = link;
						end else begin
							adv     = 1'b1;
							adv_cur = link;
						end
					end
					KIND_FIND: begin
						if (e_free) begin
							fin     = 1'b1;
							hint_we = 1'b1;
						end else begin
							adv     = 1'b1;
							adv_cur = cur_q + 28'd1;
						end
					end
					KIND_FREE: begin
						if (e_free || e_bad) begin
							fin            = 1'b1;
							fin_res.status = STAT_BADFS;
						end else begin
							tbl_req.wr_en = 1'b1;
							if (e_end) begin
								fin = 1'b1;
							end else begin
								adv     = 1'b1;
								adv_cur = link;
							end
						end
					end
					default: fin = 1'b1;    // plain read
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			hint_q  <= HINT_INIT;
			done    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done    <= fin;
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (hint_we) hint_q <= cur_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			kind_q <= cmd.kind;
			cur_q  <= (cmd.kind == KIND_FIND) ? hint_q : cmd.cluster;
			cnt_q  <= cmd.step_count;
			wv_q   <= cmd.write_value;
			ent_q  <= {4'd0, cmd.cluster};
		end else if (adv) begin
			cur_q <= adv_cur;
			ent_q <= tbl_rdata;
			cnt_q <= cnt_q - 16'd1;
		end
		if (fin) result <= fin_res;
	end

endmodule

// ===== bench/tb_fat_cluster_chain_engine_unit.sv =====
// Self-checking bench for fat_cluster_chain_engine_unit: table operations are
// predicted by a shadow allocation table kept here and compared on each done.
// Depends on fcce_pkg and the RTL of the block only.
module tb_fat_cluster_chain_engine_unit;
	import fcce_pkg::*;

	localparam int DEPTH = 4096;
	localparam int RANDOM_OPS = 1750;
	localparam int TAIL_CYCLES = 16;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cmd_t        cmd;
	logic        done;
	result_t     result;
	logic        cfg_we;
	logic [11:0] cfg_wdata;

	fat_cluster_chain_engine_unit #(.TABLE_DEPTH(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// shadow of the block state
	logic [31:0] fat_shadow [DEPTH];
	logic [27:0] shadow_hint;
	logic [11:0] shadow_count;

	cmd_t    fat_ops[$];
	result_t cluster_answers[$];
	int      mismatch_count = 0;
	int      ops_queued = 0;
	logic    cmd_fire = 1'b0;
	int      burst_left = 1;
	int      gap_left = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic result_t make_result(logic [2:0] st, logic [31:0] val, logic [27:0] cl);
		result_t r;
		r.status = st;
		r.entry_value = val;
		r.found_cluster = cl;
		return r;
	endfunction

	function automatic result_t fat_op_outcome(cmd_t op);
		logic [31:0] ent;
		logic [27:0] cur;
		int unsigned cand;
		int unsigned scan_end;
		cur = op.cluster;
		case (op.kind)
			KIND_READ: begin
				if (cur >= DEPTH) return make_result(STAT_BADDEV, ENT_EMPTY, cur);
				return make_result(STAT_OK, fat_shadow[cur], cur);
			end
			KIND_WRITE: begin
				if (cur >= DEPTH) return make_result(STAT_BADDEV, ENT_EMPTY, cur);
				fat_shadow[cur] = op.write_value;
				return make_result(STAT_OK, op.write_value, cur);
			end
			KIND_NTH: begin
				// zero steps reads nothing: the start cluster comes back as entry
				ent = {4'h0, cur};
				for (int unsigned i = 0; i < op.step_count; i++) begin
					if (cur >= DEPTH) return make_result(STAT_BADDEV, ENT_EMPTY, cur);
					ent = fat_shadow[cur];
					if (ent >= ENT_EOC) return make_result(STAT_ENDED, ent, cur);
					cur = ent[27:0];
					if (cur == LINK_BAD || cur == LINK_FREE)
						return make_result(STAT_BADFS, ent, cur);
				end
				return make_result(STAT_OK, ent, cur);
			end
			KIND_FIND: begin
				scan_end = shadow_count + 2;
				for (cand = shadow_hint; cand < scan_end; cand++) begin
					if (cand >= DEPTH) return make_result(STAT_BADDEV, ENT_EMPTY, cand[27:0]);
					if (fat_shadow[cand][27:0] == LINK_FREE) begin
						shadow_hint = cand[27:0];
						return make_result(STAT_OK, fat_shadow[cand], cand[27:0]);
					end
				end
				return make_result(STAT_FULL, ENT_EMPTY, '0);
			end
			KIND_FREE: begin
				// zeroed entries end any loop as a free link
				while (1'b1) begin
					if (cur >= DEPTH) return make_result(STAT_BADDEV, ENT_EMPTY, cur);
					ent = fat_shadow[cur];
					if (ent[27:0] == LINK_FREE || ent[27:0] == LINK_BAD)
						return make_result(STAT_BADFS, ent, cur);
					fat_shadow[cur] = ENT_EMPTY;
					if (ent >= ENT_EOC) return make_result(STAT_OK, ent, cur);
					cur = ent[27:0];
				end
			end
			default: return make_result(STAT_BADDEV, ENT_EMPTY, '0);
		endcase
		return make_result(STAT_BADDEV, ENT_EMPTY, '0);
	endfunction

	// result check, then prediction of any transaction taken at this edge
	always @(posedge clk) begin
		result_t want;
		logic taken;
		if (arst_n) begin
			taken = start && busy === 1'b0;
			if (done !== 1'b0) begin
				if (cluster_answers.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result: status %0d entry %h cluster %h",
							result.status, result.entry_value, result.found_cluster);
				end else begin
					want = cluster_answers.pop_front();
					if (result.status !== want.status || result.entry_value !== want.entry_value ||
						result.found_cluster !== want.found_cluster) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: status %0d/%0d entry %h/%h cluster %h/%h (exp/got)",
								want.status, result.status, want.entry_value, result.entry_value,
								want.found_cluster, result.found_cluster);
					end
				end
			end
			if (taken) cluster_answers.push_back(fat_op_outcome(cmd));
			cmd_fire <= taken;
		end
	end

	// command driver: bursts of random length, random gaps between them
	always @(negedge clk) begin
		logic hold;
		cmd_t next_op;
		hold = start && !cmd_fire;
		next_op = cmd;
		if (!hold) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (fat_ops.size() != 0) begin
				next_op = fat_ops.pop_front();
				hold = 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end
		end
		start <= hold;
		cmd <= next_op;
	end

	task automatic queue_op(logic [2:0] kind, logic [27:0] cl, logic [15:0] steps,
		logic [31:0] val);
		cmd_t op;
		op.kind = kind;
		op.cluster = cl;
		op.step_count = steps;
		op.write_value = val;
		fat_ops.push_back(op);
		ops_queued++;
	endtask

	// hold off until every queued transaction has been answered
	task automatic drain();
		do @(posedge clk);
		while (fat_ops.size() != 0 || start || busy !== 1'b0 || cluster_answers.size() != 0);
	endtask

	task automatic set_cluster_count(logic [11:0] value);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		shadow_count = value;
	endtask

	function automatic logic [27:0] pick_cluster();
		if ($urandom_range(0, 3) == 0) return 28'($urandom_range(2, 40));
		return 28'($urandom_range(2, DEPTH - 1));
	endfunction

	// a linked chain with a random tail, then walks over it and may free it
	task automatic build_chain();
		logic [27:0] links [8];
		logic [31:0] tail;
		int len;
		len = $urandom_range(1, 8);
		for (int i = 0; i < len; i++) links[i] = pick_cluster();
		for (int i = 0; i < len - 1; i++)
			queue_op(KIND_WRITE, links[i], 16'($urandom),
				{($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'h0, links[i + 1]});
		case ($urandom_range(0, 9))
			0, 1, 2: tail = {4'h0, 28'($urandom_range(28'hFFFFFF8, 28'hFFFFFFF))};
			3, 4, 5: tail = $urandom_range(32'h0FFFFFF8, 32'hFFFFFFFF);
			6: tail = {4'h0, LINK_BAD};
			7: tail = {4'h0, ($urandom_range(0, 1) == 0) ? LINK_FREE : pick_cluster()};
			8: tail = {4'h0, 28'($urandom_range(DEPTH, 28'hFFFFFFF))};
			default: tail = {4'h0, links[$urandom_range(0, len - 1)]};
		endcase
		queue_op(KIND_WRITE, links[len - 1], 16'($urandom), tail);
		queue_op(KIND_NTH, links[0], 16'($urandom_range(0, len + 2)), $urandom);
		if ($urandom_range(0, 2) == 0)
			queue_op(KIND_READ, links[$urandom_range(0, len - 1)], 16'($urandom), $urandom);
		if ($urandom_range(0, 2) == 0)
			queue_op(KIND_NTH, links[$urandom_range(0, len - 1)], 16'($urandom_range(0, 9)),
				$urandom);
		if ($urandom_range(0, 2) != 0)
			queue_op(KIND_FREE, links[($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : 0],
				16'($urandom), $urandom);
	endtask

	// find free, then claim the cluster it returned
	task automatic allocate_cluster();
		queue_op(KIND_FIND, 28'($urandom), 16'($urandom), $urandom);
		drain();
		queue_op(KIND_WRITE, shadow_hint, 16'($urandom),
			($urandom_range(0, 1) == 0) ? ENT_EOC : {4'h0, pick_cluster()});
	endtask

	task automatic random_op();
		logic [2:0] kind;
		logic [27:0] cl;
		logic [15:0] steps;
		logic [31:0] val;
		case ($urandom_range(0, 9))
			0, 1: kind = KIND_READ;
			2, 3: kind = KIND_WRITE;
			4, 5: kind = KIND_NTH;
			6: kind = KIND_FIND;
			7, 8: kind = KIND_FREE;
			default: kind = KIND_FREE + 3'($urandom_range(1, 3));
		endcase
		case ($urandom_range(0, 7))
			0: cl = 28'($urandom_range(DEPTH - 8, DEPTH + 8));
			1: cl = 28'($urandom);
			default: cl = 28'($urandom_range(0, DEPTH - 1));
		endcase
		steps = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
		case ($urandom_range(0, 5))
			0, 1: val = $urandom;
			2, 3: val = {4'h0, pick_cluster()};
			4: val = ($urandom_range(0, 1) == 0) ? ENT_EMPTY : {4'h0, LINK_BAD};
			default: val = ($urandom_range(0, 1) == 0) ? ENT_EOC : 32'hFFFF_FFFF;
		endcase
		queue_op(kind, cl, steps, val);
	endtask

	initial begin
		int pick;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		foreach (fat_shadow[i]) fat_shadow[i] = ENT_EMPTY;
		shadow_hint = HINT_INIT;
		shadow_count = 12'd4094;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// smallest volume: only cluster 2 can be scanned
		set_cluster_count(12'd1);
		queue_op(KIND_FIND, '0, '0, '0);
		queue_op(KIND_WRITE, 28'd2, '0, ENT_EOC);
		queue_op(KIND_FIND, '0, '0, '0);
		set_cluster_count(12'd0);
		queue_op(KIND_FIND, '0, '0, '0);

		set_cluster_count(12'd4094);
		queue_op(KIND_READ, 28'd0, '0, '0);
		queue_op(KIND_READ, 28'(DEPTH), '0, '0);
		queue_op(KIND_FIND, '0, '0, '0);
		queue_op(KIND_WRITE, 28'd3, '0, 32'd4);
		queue_op(KIND_WRITE, 28'd4, '0, 32'd5);
		// high nibble set makes it an end mark although the link bits are free
		queue_op(KIND_WRITE, 28'd5, '0, 32'hF000_0000);
		queue_op(KIND_NTH, 28'd3, 16'd0, '0);
		queue_op(KIND_NTH, 28'd3, 16'd2, '0);
		queue_op(KIND_NTH, 28'd3, 16'hFFFF, '0);
		queue_op(KIND_WRITE, 28'd6, '0, {4'h0, LINK_BAD});
		queue_op(KIND_NTH, 28'd6, 16'd1, '0);
		queue_op(KIND_WRITE, 28'd7, '0, 32'd7);
		queue_op(KIND_NTH, 28'd7, 16'hFFFF, '0);
		queue_op(KIND_FREE, 28'd3, '0, '0);
		queue_op(KIND_FREE, 28'd7, '0, '0);
		queue_op(KIND_WRITE, 28'd8, '0, 32'(DEPTH));
		queue_op(KIND_NTH, 28'd8, 16'd5, '0);
		queue_op(KIND_FREE, 28'd8, '0, '0);
		queue_op(KIND_WRITE, 28'(DEPTH - 1), 16'hFFFF, 32'hFFFF_FFFF);
		queue_op(KIND_WRITE, 28'(DEPTH), '0, 32'hFFFF_FFFF);
		queue_op(KIND_NTH, 28'hFFF_FFFF, 16'd1, '0);
		for (int k = 1; k <= 3; k++)
			queue_op(KIND_FREE + 3'(k), 28'($urandom), 16'($urandom), $urandom);

		ops_queued = 0;
		while (ops_queued < RANDOM_OPS) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				build_chain();
			end else if (pick < 52) begin
				allocate_cluster();
			end else if (pick < 92) begin
				random_op();
			end else if (pick < 96) begin
				drain();
			end else begin
				case ($urandom_range(0, 9))
					0: set_cluster_count(12'd0);
					1: set_cluster_count(12'd1);
					2: set_cluster_count(12'd4095);
					3, 4: set_cluster_count(12'($urandom));
					default: set_cluster_count(12'd4094);
				endcase
			end
		end

		// largest volume: the scan reaches one entry past the end of the table
		set_cluster_count(12'd4095);
		queue_op(KIND_FIND, '0, '0, '0);
		set_cluster_count(12'd4094);
		queue_op(KIND_FIND, '0, '0, '0);

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && cluster_answers.size() == 0)
			$display("tb_fat_cluster_chain_engine_unit passed");
		else
			$display("tb_fat_cluster_chain_engine_unit failed");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("tb_fat_cluster_chain_engine_unit failed");
		$finish;
	end

endmodule
